// ===== design/bgpf_pkg.sv =====
`default_nettype none

package bgpf_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_CODE   = 2'd0,
      CMD_LOAD_BITMAP = 2'd1,
      CMD_PIXEL       = 2'd2,
      CMD_ROW_BYTE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_GLYPH_COUNT  = 2'd0,
      CSR_GLYPH_HEIGHT = 2'd1,
      CSR_GLYPH_WIDTH  = 2'd2
   } csr_idx_type;

   localparam int COUNT_W  = 8;
   localparam int HEIGHT_W = 6;
   localparam int WIDTH_W  = 6;
   localparam int BPR_W    = 4;
   localparam int LIN_W    = 14;
   localparam int FETCH_W  = 18;

   localparam logic [COUNT_W-1:0]  GLYPH_COUNT_RST  = 8'd0;
   localparam logic [HEIGHT_W-1:0] GLYPH_HEIGHT_RST = 6'd8;
   localparam logic [WIDTH_W-1:0]  GLYPH_WIDTH_RST  = 6'd8;

endpackage

`default_nettype wire

// ===== design/bitmap_glyph_pixel_fetch_core.sv =====
// A load, a blank-row query or a query on an empty table goes straight to the finish state;
// else the search reads N code entries (1 to MAX_GLYPHS), one per cycle; a miss then finishes,
// a hit passes MUL0, MUL1, FETCH and DATA (no DATA if the address is past the store). One
// transaction in flight; the next is accepted once the result is registered,
// which waits while the previous result is held. Reset (synchronous, active high) clears
// control state, the search position and registers to 0/8/8; memories are not cleared.
`default_nettype none

module bitmap_glyph_pixel_fetch_core #(
   parameter int MAX_GLYPHS   = 128,
   parameter int BITMAP_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [12:0] req_table_address,
   input  wire logic [7:0]  req_load_value,
   input  wire logic [7:0]  req_letter,
   input  wire logic [4:0]  req_column,
   input  wire logic [7:0]  req_row,
   input  wire logic [1:0]  req_byte_in_row,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found,
   output logic             rsp_pixel,
   output logic [7:0]       rsp_row_byte
);

   import bgpf_pkg::*;

   localparam int CA_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int BA_W = $clog2(BITMAP_BYTES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL0,
      S_MUL1,
      S_FETCH,
      S_DATA,
      S_FINISH
   } state_type;

   state_type             state_ff;
   logic [COUNT_W-1:0]    glyph_count_ff;
   logic [HEIGHT_W-1:0]   glyph_height_ff;
   logic [WIDTH_W-1:0]    glyph_width_ff;
   logic [CA_W-1:0]       search_ff;
   logic [CA_W-1:0]       pos_ff;
   logic                  first_ff;
   logic                  up_ff;
   cmd_type               cmd_ff;
   logic [7:0]            letter_ff;
   logic [4:0]            column_ff;
   logic [7:0]            row_ff;
   logic [1:0]            byte_ff;
   logic [LIN_W-1:0]      lin_ff;
   logic [FETCH_W-1:0]    addr_ff;
   logic                  res_found_ff;
   logic                  res_pixel_ff;
   logic [7:0]            res_byte_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic                  rsp_pixel_ff;
   logic [7:0]            rsp_byte_ff;

   logic [COUNT_W-1:0]    count;
   logic [COUNT_W-1:0]    pos_w;
   logic [CA_W-1:0]       start_pos;
   logic [CA_W-1:0]       next_pos;
   logic [CA_W-1:0]       code_raddr;
   logic [7:0]            code_rdata;
   logic [7:0]            bmp_rdata;
   logic                  hit;
   logic                  up_in;
   logic                  at_end;
   logic [BPR_W-1:0]      bpr;
   logic [1:0]            offset;
   logic [FETCH_W-1:0]    ld_addr;
   logic                  req_fire;
   logic                  code_we;
   logic                  bmp_we;
   cmd_type               req_cmd;

   // a pending register write goes first
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_cmd   = cmd_type'(req_command);
   assign ld_addr   = FETCH_W'(req_table_address);
   assign code_we   = req_fire && (req_cmd == CMD_LOAD_CODE) &&
                      (ld_addr < FETCH_W'(MAX_GLYPHS));
   assign bmp_we    = req_fire && (req_cmd == CMD_LOAD_BITMAP) &&
                      (ld_addr < FETCH_W'(BITMAP_BYTES));

   always_comb begin
      count = ({1'b0, glyph_count_ff} > 9'(MAX_GLYPHS)) ? COUNT_W'(MAX_GLYPHS)
                                                        : glyph_count_ff;
      start_pos  = (COUNT_W'(search_ff) >= count) ? CA_W'(count - 8'd1) : search_ff;
      pos_w      = COUNT_W'(pos_ff);
      hit        = (code_rdata == letter_ff);
      up_in      = first_ff ? (code_rdata < letter_ff) : up_ff;
      at_end     = up_in ? (pos_w == count - 8'd1) : (pos_ff == '0);
      next_pos   = up_in ? pos_ff + CA_W'(1) : pos_ff - CA_W'(1);
      code_raddr = (state_ff == S_IDLE) ? start_pos : next_pos;
      bpr        = BPR_W'((7'(glyph_width_ff) + 7'd7) >> 3);
      offset     = (cmd_ff == CMD_PIXEL) ? column_ff[4:3] : byte_ff;
   end

   bgpf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_GLYPHS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (ld_addr[CA_W-1:0]),
      .wr_data (req_load_value),
      .rd_addr (code_raddr),
      .rd_data (code_rdata)
   );

   bgpf_ram #(
      .WIDTH (8),
      .DEPTH (BITMAP_BYTES)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bmp_we),
      .wr_addr (ld_addr[BA_W-1:0]),
      .wr_data (req_load_value),
      .rd_addr (addr_ff[BA_W-1:0]),
      .rd_data (bmp_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         glyph_count_ff  <= GLYPH_COUNT_RST;
         glyph_height_ff <= GLYPH_HEIGHT_RST;
         glyph_width_ff  <= GLYPH_WIDTH_RST;
         search_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_GLYPH_COUNT:  glyph_count_ff  <= csr_data;
               CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_data[HEIGHT_W-1:0];
               CSR_GLYPH_WIDTH:  glyph_width_ff  <= csr_data[WIDTH_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  cmd_ff       <= req_cmd;
                  letter_ff    <= req_letter;
                  column_ff    <= req_column;
                  row_ff       <= req_row;
                  byte_ff      <= req_byte_in_row;
                  res_found_ff <= 1'b0;
                  res_pixel_ff <= 1'b0;
                  res_byte_ff  <= 8'd0;
                  pos_ff       <= start_pos;
                  first_ff     <= 1'b1;
                  if ((req_cmd == CMD_LOAD_CODE) || (req_cmd == CMD_LOAD_BITMAP) ||
                      (req_row >= 8'(glyph_height_ff)) || (count == '0)) begin
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               first_ff <= 1'b0;
               up_ff    <= up_in;
               if (hit) begin
                  search_ff <= pos_ff;
                  state_ff  <= S_MUL0;
               end else if (at_end) begin
                  search_ff <= pos_ff;
                  state_ff  <= S_FINISH;
               end else begin
                  pos_ff <= next_pos;
               end
            end
            S_MUL0: begin
               lin_ff   <= LIN_W'(pos_w) * LIN_W'(glyph_height_ff) + LIN_W'(row_ff);
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               addr_ff  <= FETCH_W'(lin_ff) * FETCH_W'(bpr) + FETCH_W'(offset);
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               if (addr_ff < FETCH_W'(BITMAP_BYTES)) begin
                  state_ff <= S_DATA;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_DATA: begin
               res_found_ff <= 1'b1;
               res_pixel_ff <= (cmd_ff == CMD_PIXEL) ? bmp_rdata[3'd7 - column_ff[2:0]] : 1'b0;
               res_byte_ff  <= (cmd_ff == CMD_ROW_BYTE) ? bmp_rdata : 8'd0;
               state_ff     <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= res_found_ff;
                  rsp_pixel_ff <= res_pixel_ff;
                  rsp_byte_ff  <= res_byte_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_pixel    = rsp_pixel_ff;
   assign rsp_row_byte = rsp_byte_ff;

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (pos_w < count))
      else $error("search position outside code table");

   a_blank_when_missing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (!rsp_pixel && (rsp_row_byte == 8'd0)))
      else $error("blank result carries data");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule

`default_nettype wire

// ===== design/bgpf_ram.sv =====
`default_nettype none

module bgpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/bitmap_glyph_pixel_fetch_core_test.sv =====
`timescale 1ns / 100ps

module bitmap_glyph_pixel_fetch_core_test;
   import bgpf_pkg::*;

   localparam int GLYPH_SLOTS = 128;
   localparam int BITMAP_SIZE = 8192;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      cmd_type     command;
      logic [12:0] table_address;
      logic [7:0]  load_value;
      logic [7:0]  letter;
      logic [4:0]  column;
      logic [7:0]  row;
      logic [1:0]  byte_in_row;
   } glyph_req_type;

   typedef struct packed {
      logic       found;
      logic       pixel;
      logic [7:0] row_byte;
   } glyph_rsp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [12:0] req_table_address;
   logic [7:0]  req_load_value;
   logic [7:0]  req_letter;
   logic [4:0]  req_column;
   logic [7:0]  req_row;
   logic [1:0]  req_byte_in_row;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_found;
   logic        rsp_pixel;
   logic [7:0]  rsp_row_byte;

   // predictor state
   logic [7:0] code_tbl [GLYPH_SLOTS];
   logic [7:0] bitmap_mem [BITMAP_SIZE];
   bit         bitmap_set [BITMAP_SIZE];
   int         search_pos = 0;
   int         cfg_count = 0;
   int         cfg_height = 8;
   int         cfg_width = 8;

   glyph_rsp_type glyph_fetch_q [$];
   int         errors = 0;
   int         cycle_count = 0;
   bit         throttle = 1'b1;
   bit         hold_req = 1'b0;
   int         hold_left = 0;
   int         stall_left = 0;

   bitmap_glyph_pixel_fetch_core #(
      .MAX_GLYPHS(GLYPH_SLOTS),
      .BITMAP_BYTES(BITMAP_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_table_address(req_table_address),
      .req_load_value(req_load_value),
      .req_letter(req_letter),
      .req_column(req_column),
      .req_row(req_row),
      .req_byte_in_row(req_byte_in_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_pixel(rsp_pixel),
      .rsp_row_byte(rsp_row_byte)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // linear search from the remembered position; does not touch the position itself
   function automatic bit locate_glyph(input logic [7:0] letter, input int start,
                                       output int glyph, output int next_pos);
      int cnt;
      int p;
      cnt = (cfg_count > GLYPH_SLOTS) ? GLYPH_SLOTS : cfg_count;
      glyph = 0;
      next_pos = start;
      if (cnt == 0)
         return 1'b0;
      p = (start >= cnt) ? cnt - 1 : start;
      if (code_tbl[p] < letter) begin
         while (p < cnt) begin
            if (code_tbl[p] == letter) begin
               glyph = p;
               next_pos = p;
               return 1'b1;
            end
            p++;
         end
         next_pos = cnt - 1;
         return 1'b0;
      end
      while (p >= 0) begin
         if (code_tbl[p] == letter) begin
            glyph = p;
            next_pos = p;
            return 1'b1;
         end
         p--;
      end
      next_pos = 0;
      return 1'b0;
   endfunction

   function automatic int fetch_address(input int glyph, input glyph_req_type it);
      int bpr;
      int offset;
      bpr = (cfg_width + 7) / 8;
      offset = (it.command == CMD_PIXEL) ? int'(it.column >> 3) : int'(it.byte_in_row);
      return glyph * cfg_height * bpr + int'(it.row) * bpr + offset;
   endfunction

   function automatic glyph_rsp_type compute_glyph_fetch(input glyph_req_type it);
      glyph_rsp_type rsp;
      int         glyph;
      int         next_pos;
      int         addr;
      bit         hit;
      logic [7:0] data;
      rsp = '0;
      case (it.command)
         CMD_LOAD_CODE: begin
            if (it.table_address < GLYPH_SLOTS)
               code_tbl[it.table_address] = it.load_value;
         end
         CMD_LOAD_BITMAP: begin
            if (it.table_address < BITMAP_SIZE) begin
               bitmap_mem[it.table_address] = it.load_value;
               bitmap_set[it.table_address] = 1'b1;
            end
         end
         default: begin
            if (it.row < cfg_height) begin
               hit = locate_glyph(it.letter, search_pos, glyph, next_pos);
               search_pos = next_pos;
               if (hit) begin
                  addr = fetch_address(glyph, it);
                  if (addr < BITMAP_SIZE) begin
                     data = bitmap_mem[addr];
                     rsp.found = 1'b1;
                     if (it.command == CMD_PIXEL)
                        rsp.pixel = data[7 - it.column[2:0]];
                     else
                        rsp.row_byte = data;
                  end
               end
            end
         end
      endcase
      return rsp;
   endfunction

   function automatic glyph_req_type random_item();
      glyph_req_type it;
      it.command = cmd_type'($urandom_range(0, 3));
      it.table_address = 13'($urandom);
      it.load_value = 8'($urandom);
      it.letter = 8'($urandom);
      it.column = 5'($urandom);
      it.row = 8'($urandom);
      it.byte_in_row = 2'($urandom);
      return it;
   endfunction

   function automatic glyph_req_type make_load(input cmd_type cmd, input logic [12:0] addr,
                                               input logic [7:0] value);
      glyph_req_type it;
      it = '0;
      it.command = cmd;
      it.table_address = addr;
      it.load_value = value;
      return it;
   endfunction

   function automatic glyph_req_type make_query(input cmd_type cmd, input logic [7:0] letter,
                                                input logic [7:0] row, input logic [4:0] column,
                                                input logic [1:0] byte_off);
      glyph_req_type it;
      it = '0;
      it.command = cmd;
      it.letter = letter;
      it.row = row;
      it.column = column;
      it.byte_in_row = byte_off;
      return it;
   endfunction

   task automatic send_item(input glyph_req_type it);
      @(negedge clock);
      if (throttle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_command <= it.command;
      req_table_address <= it.table_address;
      req_load_value <= it.load_value;
      req_letter <= it.letter;
      req_column <= it.column;
      req_row <= it.row;
      req_byte_in_row <= it.byte_in_row;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      glyph_fetch_q.push_back(compute_glyph_fetch(it));
   endtask

   // a query that would fetch a bitmap byte never loaded gets that byte loaded first
   task automatic issue_request(input glyph_req_type it);
      int         glyph;
      int         next_pos;
      int         addr;
      glyph_req_type fill;
      if (it.command inside {CMD_PIXEL, CMD_ROW_BYTE} && it.row < cfg_height &&
          locate_glyph(it.letter, search_pos, glyph, next_pos)) begin
         addr = fetch_address(glyph, it);
         if (addr < BITMAP_SIZE && !bitmap_set[addr]) begin
            fill = random_item();
            fill.command = CMD_LOAD_BITMAP;
            fill.table_address = 13'(addr);
            send_item(fill);
         end
      end
      send_item(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (glyph_fetch_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_GLYPH_COUNT:  cfg_count = int'(value);
         CSR_GLYPH_HEIGHT: cfg_height = int'(value[5:0]);
         default:          cfg_width = int'(value[5:0]);
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_font_format(input int count, input int height, input int width);
      logic [7:0] value;
      wait_idle();
      write_csr(CSR_GLYPH_COUNT, 8'(count));
      value = 8'($urandom);
      value[5:0] = 6'(height);
      write_csr(CSR_GLYPH_HEIGHT, value);
      value = 8'($urandom);
      value[5:0] = 6'(width);
      write_csr(CSR_GLYPH_WIDTH, value);
   endtask

   task automatic load_code_table(input int count, input bit sorted);
      int n;
      int idx;
      int v;
      n = (count > GLYPH_SLOTS) ? GLYPH_SLOTS : count;
      idx = 0;
      if (sorted) begin
         for (v = 0; v < 256; v++) begin
            if (idx < n && $urandom_range(0, 255 - v) < n - idx) begin
               send_item(make_load(CMD_LOAD_CODE, 13'(idx), 8'(v)));
               idx++;
            end
         end
      end else begin
         for (idx = 0; idx < n; idx++)
            send_item(make_load(CMD_LOAD_CODE, 13'(idx), 8'($urandom)));
      end
   endtask

   task automatic run_font_phase(input int count, input int height, input int width,
                                 input bit sorted, input bit hold, input int n_items);
      glyph_req_type it;
      int         sent;
      int         eff;
      int         pick;
      int         bpr;
      load_code_table(count, sorted);
      set_font_format(count, height, width);
      if (hold)
         hold_req = 1'b1;
      eff = (cfg_count > GLYPH_SLOTS) ? GLYPH_SLOTS : cfg_count;
      bpr = (cfg_width + 7) / 8;
      sent = 0;
      while (sent < n_items) begin
         it = random_item();
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            it.command = $urandom_range(0, 1) ? CMD_PIXEL : CMD_ROW_BYTE;
            if (eff > 0)
               it.letter = code_tbl[$urandom_range(0, eff - 1)];
            if (cfg_height > 0)
               it.row = 8'($urandom_range(0, cfg_height - 1));
            if ($urandom_range(0, 3) != 0 && cfg_width > 0) begin
               it.column = 5'($urandom_range(0, ((cfg_width > 32) ? 32 : cfg_width) - 1));
               it.byte_in_row = 2'($urandom_range(0, ((bpr > 4) ? 4 : bpr) - 1));
            end
         end else if (pick < 82) begin
            it.command = $urandom_range(0, 1) ? CMD_PIXEL : CMD_ROW_BYTE;
            if ($urandom_range(0, 1))
               it.row = 8'(cfg_height + $urandom_range(0, 3));
         end else if (pick < 94) begin
            it.command = CMD_LOAD_BITMAP;
         end else begin
            it.command = CMD_LOAD_CODE;
            if ($urandom_range(0, 1))
               it.table_address = 13'($urandom_range(0, GLYPH_SLOTS - 1));
         end
         issue_request(it);
         if (!(it.command == CMD_LOAD_CODE && it.table_address >= GLYPH_SLOTS))
            sent++;
      end
   endtask

   task automatic test_empty_table();
      issue_request(make_query(CMD_PIXEL, 8'h41, 8'd0, 5'd0, 2'd0));
      issue_request(make_query(CMD_ROW_BYTE, 8'h00, 8'd7, 5'd31, 2'd3));
   endtask

   task automatic test_load_address_range();
      send_item(make_load(CMD_LOAD_CODE, 13'd8191, 8'hFF));
      send_item(make_load(CMD_LOAD_CODE, 13'(GLYPH_SLOTS), 8'h00));
      send_item(make_load(CMD_LOAD_BITMAP, 13'd8191, 8'hFF));
      send_item(make_load(CMD_LOAD_BITMAP, 13'd0, 8'h00));
   endtask

   task automatic test_search_cases();
      send_item(make_load(CMD_LOAD_CODE, 13'd0, 8'h00));
      send_item(make_load(CMD_LOAD_CODE, 13'd1, 8'h41));
      send_item(make_load(CMD_LOAD_CODE, 13'd2, 8'h7F));
      send_item(make_load(CMD_LOAD_CODE, 13'd3, 8'hFF));
      set_font_format(4, 8, 8);
      issue_request(make_query(CMD_PIXEL, 8'h00, 8'd0, 5'd0, 2'd0));
      // upward hit; column 31 reaches past the glyph width
      issue_request(make_query(CMD_PIXEL, 8'hFF, 8'd7, 5'd31, 2'd0));
      // downward hit
      issue_request(make_query(CMD_ROW_BYTE, 8'h41, 8'd0, 5'd0, 2'd3));
      issue_request(make_query(CMD_ROW_BYTE, 8'h7F, 8'd8, 5'd0, 2'd0));
      issue_request(make_query(CMD_PIXEL, 8'h7F, 8'd255, 5'd0, 2'd0));
      // misses: upward then downward; then an upward hit
      issue_request(make_query(CMD_PIXEL, 8'h80, 8'd1, 5'd9, 2'd0));
      issue_request(make_query(CMD_ROW_BYTE, 8'h40, 8'd2, 5'd0, 2'd0));
      issue_request(make_query(CMD_ROW_BYTE, 8'hFF, 8'd3, 5'd0, 2'd1));
      // position now past the shrunken table
      set_font_format(2, 8, 8);
      issue_request(make_query(CMD_PIXEL, 8'h00, 8'd4, 5'd4, 2'd0));
      issue_request(make_query(CMD_PIXEL, 8'h7F, 8'd0, 5'd0, 2'd0));
      set_font_format(0, 8, 8);
      issue_request(make_query(CMD_ROW_BYTE, 8'h41, 8'd0, 5'd0, 2'd0));
      set_font_format(4, 8, 8);
      issue_request(make_query(CMD_ROW_BYTE, 8'h41, 8'd5, 5'd0, 2'd0));
   endtask

   task automatic test_random_fonts();
      run_font_phase(16, 8, 8, 1'b1, 1'b0, 120);
      run_font_phase(128, 32, 32, 1'b1, 1'b0, 120);
      run_font_phase(1, 1, 1, 1'b1, 1'b0, 120);
      run_font_phase(200, 16, 12, 1'b1, 1'b0, 120);
      run_font_phase(255, 32, 1, 1'b0, 1'b0, 120);
      run_font_phase(40, 12, 17, 1'b0, 1'b0, 120);
      run_font_phase($urandom_range(2, 64), $urandom_range(1, 32), $urandom_range(1, 32),
                     1'b1, 1'b0, 120);
   endtask

   task automatic test_response_backpressure();
      run_font_phase(24, 10, 9, 1'b1, 1'b1, 60);
   endtask

   task automatic test_unthrottled();
      throttle = 1'b0;
      run_font_phase(48, 20, 24, 1'b1, 1'b0, 200);
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (throttle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] expv,
                                  input logic [7:0] actv);
      errors++;
      if (errors <= 100)
         $display("%0t: %s expected %h actual %h", $time, what, expv, actv);
   endtask

   always @(posedge clock) begin : check_results
      glyph_rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (glyph_fetch_q.size() == 0) begin
            errors++;
            $display("%0t: result with no transaction outstanding", $time);
         end else begin
            exp_rsp = glyph_fetch_q.pop_front();
            if (rsp_found !== exp_rsp.found)
               report_mismatch("found", 8'(exp_rsp.found), 8'(rsp_found));
            if (rsp_pixel !== exp_rsp.pixel)
               report_mismatch("pixel", 8'(exp_rsp.pixel), 8'(rsp_pixel));
            if (rsp_row_byte !== exp_rsp.row_byte)
               report_mismatch("row_byte", exp_rsp.row_byte, rsp_row_byte);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[bitmap_glyph_pixel_fetch_core] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_GLYPH_COUNT;
      csr_data = '0;
      req_valid = 1'b0;
      req_command = CMD_LOAD_CODE;
      req_table_address = '0;
      req_load_value = '0;
      req_letter = '0;
      req_column = '0;
      req_row = '0;
      req_byte_in_row = '0;
      rsp_ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_load_address_range();
      test_search_cases();
      test_random_fonts();
      test_response_backpressure();
      test_unthrottled();

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("[bitmap_glyph_pixel_fetch_core] OK");
      else
         $display("[bitmap_glyph_pixel_fetch_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/bgpf_pkg.sv
design/bgpf_ram.sv
design/bitmap_glyph_pixel_fetch_core.sv
tb/bitmap_glyph_pixel_fetch_core_test.sv
